/* hw/rtl/slcr_pkg.sv */
// Shared types and constants for the stroke line canvas rasterizer.
// Used by the controller, datapath, top level and checker; no dependencies of its own.
`timescale 1ns / 1ps

package slcr_pkg;

  // item field widths
  localparam int MODE_W  = 2;
  localparam int XCOORD_W = 9;
  localparam int YCOORD_W = 8;
  localparam int CIDX_W  = 5;
  localparam int CELL_W  = 8;
  localparam int STEP_W  = 9;

  // item opcodes (code 3 is unused and returns an all-zero result)
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STROKE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  localparam logic [CELL_W-1:0] INK_VALUE = 8'd255;
  localparam logic [STEP_W-1:0] STEP_MAX  = 9'd511;

  // mark sequence runs over four phases: read above; read center, write above; read below, write center; write below
  localparam logic [1:0] MARK_LAST = 2'd3;

  typedef struct packed {
    logic       load;      // latch the accepted item
    logic       clear;     // wipe the canvas
    logic       setup;     // compute line deltas
    logic       walk;      // emit a point if no mark is pending
    logic       mark;      // run one mark phase
    logic [1:0] phase;
    logic       rd_item;   // read the cell row asked for by a read item
    logic       out_load;  // capture the result into the output register
  } slcr_cmd_t;

  typedef struct packed {
    logic mark_needed;
    logic walk_fin;
  } slcr_stat_t;

endpackage

/* hw/rtl/slcr_canvas.sv */
// Canvas storage: one row of GRID_SIDE bits per entry, with a valid flag per row.
// A row whose flag is low reads as zero, so a clear only drops the row flags.
`timescale 1ns / 1ps

module slcr_canvas #(
  parameter int GRID_SIDE = 28
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         rd_en,
  input  logic [$clog2(GRID_SIDE)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(GRID_SIDE)-1:0] wr_addr,
  input  logic [GRID_SIDE-1:0]         wr_data,
  output logic [GRID_SIDE-1:0]         rd_data
);

  logic [GRID_SIDE-1:0] mem [GRID_SIDE];
  logic [GRID_SIDE-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

/* hw/rtl/slcr_dp.sv */
// Datapath: item registers, Bresenham walker, point-to-cell mapping, mark
// sequencing into the canvas, and the result register. Uses slcr_pkg, slcr_canvas.
`timescale 1ns / 1ps

module slcr_dp #(
  parameter int GRID_SIDE     = 28,
  parameter int CELL_SIZE     = 8,
  parameter int GRID_X_OFFSET = 48,
  parameter int GRID_Y_OFFSET = 8,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                                clk,
  input  logic                                rst,
  input  slcr_pkg::slcr_cmd_t                 cmd,
  output slcr_pkg::slcr_stat_t                stat,
  input  logic [slcr_pkg::MODE_W-1:0]         mode,
  input  logic [slcr_pkg::XCOORD_W-1:0]       x_start,
  input  logic [slcr_pkg::YCOORD_W-1:0]       y_start,
  input  logic [slcr_pkg::XCOORD_W-1:0]       x_end,
  input  logic [slcr_pkg::YCOORD_W-1:0]       y_end,
  input  logic [slcr_pkg::CIDX_W-1:0]         read_row,
  input  logic [slcr_pkg::CIDX_W-1:0]         read_col,
  output logic [slcr_pkg::CELL_W-1:0]         cell_value,
  output logic [slcr_pkg::STEP_W-1:0]         step_count
);

  localparam int IW   = $clog2(GRID_SIDE);
  localparam int XW   = $clog2(SCREEN_WIDTH);
  localparam int YW   = $clog2(SCREEN_HEIGHT);
  localparam int MW   = (XW > YW) ? XW : YW;
  localparam int EW   = MW + 3;
  localparam int SPAN = GRID_SIDE * CELL_SIZE;
  localparam int DW   = $clog2(SPAN);
  localparam int OW0  = (MW > 8) ? MW : 8;
  localparam int OW   = (OW0 > DW + 1) ? OW0 : DW + 1;
  localparam int RLW  = OW + 2;
  // exact reciprocal: rx < 2^DW and rounding error < 16 keep the floor exact
  localparam int SH   = DW + 4;
  localparam int MULT = (2 ** SH + CELL_SIZE - 1) / CELL_SIZE;
  localparam int PW   = DW + SH + 1;
  localparam int SW   = IW + 2;

  // item registers
  logic [slcr_pkg::MODE_W-1:0] mode_q;
  logic [slcr_pkg::CIDX_W-1:0] item_row;
  logic [slcr_pkg::CIDX_W-1:0] item_col;
  logic [XW-1:0] x, xe;
  logic [YW-1:0] y, ye;

  // walker
  logic signed [EW-1:0] dx, dy, err;
  logic sx_neg, sy_neg;
  logic w_done;
  logic [slcr_pkg::STEP_W-1:0] count;

  // point stage and last marked cell
  logic          pv, p_in, p_last;
  logic [IW-1:0] p_col, p_row;
  logic          last_v;
  logic [IW-1:0] last_col, last_row;

  // canvas port
  logic                 rd_en, wr_en;
  logic [IW-1:0]        rd_addr, wr_addr;
  logic [GRID_SIDE-1:0] wr_data, rd_data;

  function automatic logic [XW-1:0] clamp_x(input logic [slcr_pkg::XCOORD_W-1:0] v);
    if (32'(v) > 32'(SCREEN_WIDTH - 1)) return XW'(SCREEN_WIDTH - 1);
    return XW'(v);
  endfunction

  function automatic logic [YW-1:0] clamp_y(input logic [slcr_pkg::YCOORD_W-1:0] v);
    if (32'(v) > 32'(SCREEN_HEIGHT - 1)) return YW'(SCREEN_HEIGHT - 1);
    return YW'(v);
  endfunction

  function automatic logic row_ok(input logic signed [SW-1:0] r);
    return (r >= 0) && (r < $signed(SW'(GRID_SIDE)));
  endfunction

  // ---- current point: window test and cell index
  logic signed [RLW-1:0] rx, ry;
  logic                  inx, iny;
  logic [PW-1:0]         prod_x, prod_y;
  logic                  is_last;
  logic signed [EW-1:0]  e2, err_next;
  logic                  step_x, step_y;
  logic signed [EW-1:0]  dx_set, dy_set;

  assign rx  = $signed(RLW'(x)) - $signed(RLW'(GRID_X_OFFSET));
  assign ry  = $signed(RLW'(y)) - $signed(RLW'(GRID_Y_OFFSET));
  assign inx = (rx >= 0) && (rx < $signed(RLW'(SPAN)));
  assign iny = (ry >= 0) && (ry < $signed(RLW'(SPAN)));
  assign prod_x = PW'(rx[DW-1:0]) * PW'(MULT);
  assign prod_y = PW'(ry[DW-1:0]) * PW'(MULT);
  assign is_last = (x == xe) && (y == ye);

  assign e2       = err <<< 1;
  assign step_x   = (e2 >= dy);
  assign step_y   = (e2 <= dx);
  assign err_next = err + (step_x ? dy : '0) + (step_y ? dx : '0);

  assign dx_set = (xe >= x) ? $signed(EW'(xe) - EW'(x)) : $signed(EW'(x) - EW'(xe));
  assign dy_set = (ye >= y) ? $signed(EW'(y) - EW'(ye)) : $signed(EW'(ye) - EW'(y));

  assign stat.mark_needed = pv && p_in &&
                            !(last_v && (last_col == p_col) && (last_row == p_row));
  assign stat.walk_fin    = pv && p_last && !stat.mark_needed;

  // ---- item latch and walker
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      item_row <= read_row;
      item_col <= read_col;
      x  <= clamp_x(x_start);
      y  <= clamp_y(y_start);
      xe <= clamp_x(x_end);
      ye <= clamp_y(y_end);
    end else if (cmd.setup) begin
      dx     <= dx_set;
      dy     <= dy_set;
      err    <= dx_set + dy_set;
      sx_neg <= !(x < xe);
      sy_neg <= !(y < ye);
      count  <= '0;
    end else if (cmd.walk && !stat.mark_needed && !w_done) begin
      p_in   <= inx && iny;
      p_col  <= prod_x[SH +: IW];
      p_row  <= prod_y[SH +: IW];
      p_last <= is_last;
      if (count != slcr_pkg::STEP_MAX) begin
        count <= count + 1'b1;
      end
      if (!is_last) begin
        err <= err_next;
        if (step_x) x <= sx_neg ? x - 1'b1 : x + 1'b1;
        if (step_y) y <= sy_neg ? y - 1'b1 : y + 1'b1;
      end
    end
  end

  // ---- walker control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pv     <= 1'b0;
      w_done <= 1'b0;
      last_v <= 1'b0;
    end else if (cmd.setup) begin
      pv     <= 1'b0;
      w_done <= 1'b0;
      last_v <= 1'b0;
    end else if (cmd.walk && !stat.mark_needed && !w_done) begin
      pv     <= 1'b1;
      w_done <= is_last;
    end else if (cmd.mark && (cmd.phase == slcr_pkg::MARK_LAST)) begin
      last_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark && (cmd.phase == slcr_pkg::MARK_LAST)) begin
      last_col <= p_col;
      last_row <= p_row;
    end
  end

  // ---- canvas access: read-modify-write of the three rows a mark touches
  logic signed [SW-1:0] ph_s, rd_row_s, wr_row_s;
  logic [GRID_SIDE-1:0] oh, mask;
  logic                 item_in_range;

  assign ph_s     = $signed(SW'(cmd.phase));
  assign rd_row_s = $signed(SW'(p_row)) + ph_s - $signed(SW'(1));
  assign wr_row_s = $signed(SW'(p_row)) + ph_s - $signed(SW'(2));
  assign oh       = GRID_SIDE'(1) << p_col;
  // center row gets the cell and its left and right neighbors
  assign mask     = (cmd.phase == 2'd2) ? (oh | (oh << 1) | (oh >> 1)) : oh;
  assign item_in_range = (32'(item_row) < 32'(GRID_SIDE)) &&
                         (32'(item_col) < 32'(GRID_SIDE));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_row_s[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = wr_row_s[IW-1:0];
    wr_data = rd_data | mask;
    if (cmd.rd_item) begin
      rd_en   = item_in_range;
      rd_addr = IW'(item_row);
    end else if (cmd.mark) begin
      rd_en = (cmd.phase != slcr_pkg::MARK_LAST) && row_ok(rd_row_s);
      wr_en = (cmd.phase != 2'd0) && row_ok(wr_row_s);
    end
  end

  slcr_canvas #(
    .GRID_SIDE(GRID_SIDE)
  ) u_canvas (
    .clk     (clk),
    .rst     (rst),
    .clr     (cmd.clear),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // ---- result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_value <= ((mode_q == slcr_pkg::MODE_READ) && item_in_range &&
                     rd_data[IW'(item_col)]) ? slcr_pkg::INK_VALUE : '0;
      step_count <= (mode_q == slcr_pkg::MODE_STROKE) ? count : '0;
    end
  end

endmodule

/* hw/rtl/slcr_ctrl.sv */
// Controller: item sequencing state machine and output valid flag.
// Uses slcr_pkg for opcodes and the command/status structs.
`timescale 1ns / 1ps

module slcr_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [slcr_pkg::MODE_W-1:0] mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output slcr_pkg::slcr_cmd_t         cmd,
  input  slcr_pkg::slcr_stat_t        stat
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_CLR   = 7'b000_0010,
    S_RD    = 7'b000_0100,
    S_SETUP = 7'b000_1000,
    S_WALK  = 7'b001_0000,
    S_MARK  = 7'b010_0000,
    S_FIN   = 7'b100_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] phase, phase_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.phase  = phase;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (mode)
            slcr_pkg::MODE_CLEAR:  state_next = S_CLR;
            slcr_pkg::MODE_STROKE: state_next = S_SETUP;
            slcr_pkg::MODE_READ:   state_next = S_RD;
            default:               state_next = S_FIN;
          endcase
        end
      end
      S_CLR: begin
        cmd.clear  = 1'b1;
        state_next = S_FIN;
      end
      S_RD: begin
        cmd.rd_item = 1'b1;
        state_next  = S_FIN;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.mark_needed) begin
          phase_next = '0;
          state_next = S_MARK;
        end else if (stat.walk_fin) begin
          state_next = S_FIN;
        end
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        phase_next = phase + 1'b1;
        if (phase == slcr_pkg::MARK_LAST) begin
          state_next = S_WALK;
        end
      end
      S_FIN: begin
        // hold here until the result register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/stroke_line_canvas_rasterizer_unit.sv */
// Stroke: N = max(|dx|,|dy|)+1 points are walked one per cycle; each time the walk lands in a window
// cell other than the last one marked, it stalls for 4 row read-modify-write phases.
// One item at a time: in_ready returns the cycle after the result is loaded; a held result stalls.
// Reset (rst, synchronous) clears the controller, the walker flags and all canvas row flags.
// Top level: controller and datapath, uses slcr_pkg, slcr_ctrl, slcr_dp.
`timescale 1ns / 1ps

module stroke_line_canvas_rasterizer_unit #(
  parameter int GRID_SIDE     = 28,
  parameter int CELL_SIZE     = 8,
  parameter int GRID_X_OFFSET = 48,
  parameter int GRID_Y_OFFSET = 8,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [slcr_pkg::MODE_W-1:0]   mode,
  input  logic [slcr_pkg::XCOORD_W-1:0] x_start,
  input  logic [slcr_pkg::YCOORD_W-1:0] y_start,
  input  logic [slcr_pkg::XCOORD_W-1:0] x_end,
  input  logic [slcr_pkg::YCOORD_W-1:0] y_end,
  input  logic [slcr_pkg::CIDX_W-1:0]   read_row,
  input  logic [slcr_pkg::CIDX_W-1:0]   read_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [slcr_pkg::CELL_W-1:0]   cell_value,
  output logic [slcr_pkg::STEP_W-1:0]   step_count
);

  slcr_pkg::slcr_cmd_t  cmd;
  slcr_pkg::slcr_stat_t stat;

  slcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  slcr_dp #(
    .GRID_SIDE     (GRID_SIDE),
    .CELL_SIZE     (CELL_SIZE),
    .GRID_X_OFFSET (GRID_X_OFFSET),
    .GRID_Y_OFFSET (GRID_Y_OFFSET),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .read_row   (read_row),
    .read_col   (read_col),
    .cell_value (cell_value),
    .step_count (step_count)
  );

endmodule

/* hw/rtl/slcr_checker.sv */
// Port-level checks for the rasterizer top level, attached by bind.
// Uses slcr_pkg for field widths.
`timescale 1ns / 1ps

module slcr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [slcr_pkg::CELL_W-1:0] cell_value,
  input logic [slcr_pkg::STEP_W-1:0] step_count
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_value) && $stable(step_count))
    else $error("result changed while stalled");

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_cell_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cell_value == '0 || cell_value == slcr_pkg::INK_VALUE))
    else $error("cell value neither blank nor inked");

  // a result comes from a read or from a stroke, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cell_value == '0 || step_count == '0))
    else $error("cell value and step count both set");

endmodule

bind stroke_line_canvas_rasterizer_unit slcr_checker u_slcr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cell_value (cell_value),
  .step_count (step_count)
);
